// ===== hw/rtl/rsi_pkg.sv =====
// ----------------------------------------------------------------------------
// rsi_pkg
// shared widths and types of the ray and sphere intersection pipeline
// ----------------------------------------------------------------------------
package rsi_pkg;

  localparam int COORD_W  = 24;
  localparam int RAD_W    = 23;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int A_W      = 48;
  localparam int HM_W     = 49;
  localparam int CM_W     = 50;
  localparam int SQ_W     = 98;
  localparam int DISC_W   = SQ_W + 1;
  localparam int ROOT_W   = 50;
  localparam int NUM_W    = ROOT_W + 1;
  localparam int FRAC_W   = 16;
  localparam int DIST_W   = 24;
  localparam int DIV_BITS = DIST_W;
  localparam int SAT_SH   = DIV_BITS - FRAC_W;
  localparam int DREM_W   = NUM_W + FRAC_W;
  localparam int DVS_W    = A_W + DIV_BITS;

  typedef enum logic [1:0] {
    MODE_SUB,
    MODE_ADD,
    MODE_REV
  } rsi_mode_t;

  typedef struct packed {
    logic             hit;
    rsi_mode_t        mode;
    logic [A_W-1:0]   a;
    logic [HM_W-1:0]  hm;
  } rsi_side_t;

endpackage

// ===== hw/rtl/ray_sphere_intersect_unit.sv =====
// ----------------------------------------------------------------------------
// ray_sphere_intersect_unit
// ray against sphere hit test with q8.16 ray parameter
// ----------------------------------------------------------------------------
// usage:
//   a ray (origin, direction) and a sphere (center, radius) are presented on
//   the in_ ports with start high; the transfer happens on any edge where
//   start is high and busy is low. busy is always low: a new ray may be
//   started on every clock.
//   each ray gives exactly one result, shown for one cycle with out_valid
//   high: out_hit and out_distance (unsigned q8.16, saturated to all ones
//   at 256.0 or beyond, 0 on a miss).
//   from the start transfer to the edge that takes the result, a ray passes
//   6 stages of products and sums, 50 square root stages (one root bit
//   each), 1 stage for the numerator and 25 divider stages (saturation test
//   plus one quotient bit each), then the output register.
//   throughput is one ray per cycle; results leave in start order.
//   the receiver cannot hold results off. reset empties the pipeline; rays in
//   flight are dropped and out_valid stays low until new results arrive.
// ----------------------------------------------------------------------------
module ray_sphere_intersect_unit import rsi_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [COORD_W-1:0] in_origin_x,
  input  logic signed [COORD_W-1:0] in_origin_y,
  input  logic signed [COORD_W-1:0] in_origin_z,
  input  logic signed [COORD_W-1:0] in_dir_x,
  input  logic signed [COORD_W-1:0] in_dir_y,
  input  logic signed [COORD_W-1:0] in_dir_z,
  input  logic signed [COORD_W-1:0] in_center_x,
  input  logic signed [COORD_W-1:0] in_center_y,
  input  logic signed [COORD_W-1:0] in_center_z,
  input  logic        [RAD_W-1:0]   in_radius,
  output logic                      out_valid,
  output logic                      out_hit,
  output logic        [DIST_W-1:0]  out_distance
);

  // stage 1: l = o - c
  logic                      s1_vld_r;
  logic signed [COORD_W-1:0] s1_dx_r, s1_dy_r, s1_dz_r;
  logic signed [DIFF_W-1:0]  s1_lx_r, s1_ly_r, s1_lz_r;
  logic        [RAD_W-1:0]   s1_rad_r;

  // stage 2: products
  logic                      s2_vld_r;
  logic signed [2*COORD_W-1:0]      s2_dd_r [3];
  logic signed [COORD_W+DIFF_W-1:0] s2_dl_r [3];
  logic signed [2*DIFF_W-1:0]       s2_ll_r [3];
  logic        [2*RAD_W-1:0]        s2_rr_r;

  // stage 3: a, h, c
  logic              s3_vld_r;
  logic [A_W-1:0]    s3_a_r;
  logic [HM_W-1:0]   s3_hm_r;
  logic [CM_W-1:0]   s3_cm_r;
  logic              s3_hle0_r, s3_cle0_r, s3_clt0_r;
  logic signed [HM_W+1:0] h_sum;
  logic signed [CM_W+1:0] c_sum;
  logic [A_W+1:0]         a_sum;

  // stage 4: partial products
  logic              s4_vld_r;
  logic [A_W-1:0]    s4_a_r;
  logic [HM_W-1:0]   s4_hm_r;
  logic              s4_anz_r, s4_hle0_r, s4_cle0_r, s4_clt0_r;
  logic [47:0]       s4_hhh_r;
  logic [48:0]       s4_hhl_r;
  logic [49:0]       s4_hll_r;
  logic [48:0]       s4_p00_r, s4_p01_r, s4_p10_r, s4_p11_r;

  // stage 5: h^2 and a*|c|
  logic              s5_vld_r;
  logic [A_W-1:0]    s5_a_r;
  logic [HM_W-1:0]   s5_hm_r;
  logic              s5_anz_r, s5_hle0_r, s5_cle0_r, s5_clt0_r;
  logic [SQ_W-1:0]   s5_h2_r, s5_ac_r;

  // stage 6: discriminant and root choice
  logic              s6_vld_r;
  logic [DISC_W-1:0] s6_disc_r;
  rsi_side_t         s6_side_r;
  rsi_side_t         side_nxt;
  logic              disc_neg;

  // square root
  logic              sq_vld;
  logic [ROOT_W-1:0] sq_root;
  rsi_side_t         sq_side;

  // numerator
  logic              nm_vld_r;
  logic              nm_hit_r;
  logic [NUM_W-1:0]  nm_num_r;
  logic [A_W-1:0]    nm_a_r;
  logic [NUM_W-1:0]  num_nxt;

  // divider and output
  logic              dv_vld, dv_hit, dv_sat;
  logic [DIST_W-1:0] dv_q;
  logic              out_valid_r, out_hit_r;
  logic [DIST_W-1:0] out_distance_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      s3_vld_r    <= 1'b0;
      s4_vld_r    <= 1'b0;
      s5_vld_r    <= 1'b0;
      s6_vld_r    <= 1'b0;
      nm_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_vld_r    <= start & ~busy;
      s2_vld_r    <= s1_vld_r;
      s3_vld_r    <= s2_vld_r;
      s4_vld_r    <= s3_vld_r;
      s5_vld_r    <= s4_vld_r;
      s6_vld_r    <= s5_vld_r;
      nm_vld_r    <= sq_vld;
      out_valid_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    s1_dx_r  <= in_dir_x;
    s1_dy_r  <= in_dir_y;
    s1_dz_r  <= in_dir_z;
    s1_lx_r  <= DIFF_W'(in_origin_x) - DIFF_W'(in_center_x);
    s1_ly_r  <= DIFF_W'(in_origin_y) - DIFF_W'(in_center_y);
    s1_lz_r  <= DIFF_W'(in_origin_z) - DIFF_W'(in_center_z);
    s1_rad_r <= in_radius;
  end

  always_ff @(posedge clk) begin
    s2_dd_r[0] <= s1_dx_r * s1_dx_r;
    s2_dd_r[1] <= s1_dy_r * s1_dy_r;
    s2_dd_r[2] <= s1_dz_r * s1_dz_r;
    s2_dl_r[0] <= s1_dx_r * s1_lx_r;
    s2_dl_r[1] <= s1_dy_r * s1_ly_r;
    s2_dl_r[2] <= s1_dz_r * s1_lz_r;
    s2_ll_r[0] <= s1_lx_r * s1_lx_r;
    s2_ll_r[1] <= s1_ly_r * s1_ly_r;
    s2_ll_r[2] <= s1_lz_r * s1_lz_r;
    s2_rr_r    <= s1_rad_r * s1_rad_r;
  end

  always_comb begin
    a_sum = (A_W+2)'(unsigned'(s2_dd_r[0])) + (A_W+2)'(unsigned'(s2_dd_r[1]))
          + (A_W+2)'(unsigned'(s2_dd_r[2]));
    h_sum = (HM_W+2)'(s2_dl_r[0]) + (HM_W+2)'(s2_dl_r[1]) + (HM_W+2)'(s2_dl_r[2]);
    c_sum = (CM_W+2)'(s2_ll_r[0]) + (CM_W+2)'(s2_ll_r[1]) + (CM_W+2)'(s2_ll_r[2])
          - (CM_W+2)'(s2_rr_r);
  end

  always_ff @(posedge clk) begin
    s3_a_r    <= a_sum[A_W-1:0];
    s3_hm_r   <= h_sum[HM_W+1] ? HM_W'(-h_sum) : h_sum[HM_W-1:0];
    s3_cm_r   <= c_sum[CM_W+1] ? CM_W'(-c_sum) : c_sum[CM_W-1:0];
    s3_hle0_r <= h_sum[HM_W+1] || (h_sum == '0);
    s3_cle0_r <= c_sum[CM_W+1] || (c_sum == '0);
    s3_clt0_r <= c_sum[CM_W+1];
  end

  always_ff @(posedge clk) begin
    s4_a_r    <= s3_a_r;
    s4_hm_r   <= s3_hm_r;
    s4_anz_r  <= s3_a_r != '0;
    s4_hle0_r <= s3_hle0_r;
    s4_cle0_r <= s3_cle0_r;
    s4_clt0_r <= s3_clt0_r;
    s4_hhh_r  <= s3_hm_r[48:25] * s3_hm_r[48:25];
    s4_hhl_r  <= s3_hm_r[48:25] * s3_hm_r[24:0];
    s4_hll_r  <= s3_hm_r[24:0] * s3_hm_r[24:0];
    s4_p00_r  <= s3_a_r[23:0] * s3_cm_r[24:0];
    s4_p01_r  <= s3_a_r[23:0] * s3_cm_r[49:25];
    s4_p10_r  <= s3_a_r[47:24] * s3_cm_r[24:0];
    s4_p11_r  <= s3_a_r[47:24] * s3_cm_r[49:25];
  end

  always_ff @(posedge clk) begin
    s5_a_r    <= s4_a_r;
    s5_hm_r   <= s4_hm_r;
    s5_anz_r  <= s4_anz_r;
    s5_hle0_r <= s4_hle0_r;
    s5_cle0_r <= s4_cle0_r;
    s5_clt0_r <= s4_clt0_r;
    s5_h2_r   <= (SQ_W'(s4_hhh_r) << 50) + (SQ_W'(s4_hhl_r) << 26) + SQ_W'(s4_hll_r);
    s5_ac_r   <= (SQ_W'(s4_p11_r) << 49) + (SQ_W'(s4_p10_r) << 24)
               + (SQ_W'(s4_p01_r) << 25) + SQ_W'(s4_p00_r);
  end

  always_comb begin
    disc_neg      = !s5_clt0_r && (s5_h2_r < s5_ac_r);
    side_nxt.a    = s5_a_r;
    side_nxt.hm   = s5_hm_r;
    side_nxt.hit  = s5_anz_r && !disc_neg && (s5_hle0_r || s5_cle0_r);
    if (s5_hle0_r && !s5_clt0_r) begin
      side_nxt.mode = MODE_SUB;
    end else if (s5_hle0_r) begin
      side_nxt.mode = MODE_ADD;
    end else begin
      side_nxt.mode = MODE_REV;
    end
  end

  always_ff @(posedge clk) begin
    s6_side_r <= side_nxt;
    s6_disc_r <= s5_clt0_r ? DISC_W'(s5_h2_r) + DISC_W'(s5_ac_r)
                           : DISC_W'(s5_h2_r) - DISC_W'(s5_ac_r);
  end

  rsi_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s6_vld_r),
    .in_rad   (s6_disc_r),
    .in_side  (s6_side_r),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_side (sq_side)
  );

  always_comb begin
    case (sq_side.mode)
      MODE_SUB: num_nxt = NUM_W'(sq_side.hm) - NUM_W'(sq_root);
      MODE_ADD: num_nxt = NUM_W'(sq_side.hm) + NUM_W'(sq_root);
      default:  num_nxt = NUM_W'(sq_root) - NUM_W'(sq_side.hm);
    endcase
  end

  always_ff @(posedge clk) begin
    nm_hit_r <= sq_side.hit;
    nm_num_r <= num_nxt;
    nm_a_r   <= sq_side.a;
  end

  rsi_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (nm_vld_r),
    .in_hit  (nm_hit_r),
    .in_num  (nm_num_r),
    .in_a    (nm_a_r),
    .out_vld (dv_vld),
    .out_hit (dv_hit),
    .out_sat (dv_sat),
    .out_q   (dv_q)
  );

  // result ports read zero between transfers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_hit_r      <= 1'b0;
      out_distance_r <= '0;
    end else if (dv_vld && dv_hit) begin
      out_hit_r      <= 1'b1;
      out_distance_r <= dv_sat ? '1 : dv_q;
    end else begin
      out_hit_r      <= 1'b0;
      out_distance_r <= '0;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_hit      = out_hit_r;
  assign out_distance = out_distance_r;

  a_no_strobe_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  a_quiet_between: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !out_hit && out_distance == '0)
    else $error("result ports active without strobe");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_distance == '0)
    else $error("miss with nonzero distance");

  a_zero_dir_miss: assert property (@(posedge clk) disable iff (!rst_n)
    s6_vld_r && s6_side_r.hit |-> s6_side_r.a != '0)
    else $error("hit flagged for zero direction");

endmodule

// ===== hw/rtl/rsi_sqrt.sv =====
// ----------------------------------------------------------------------------
// rsi_sqrt
// pipelined integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module rsi_sqrt import rsi_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  logic [DISC_W-1:0] in_rad,
  input  rsi_side_t         in_side,
  output logic              out_vld,
  output logic [ROOT_W-1:0] out_root,
  output rsi_side_t         out_side
);

  logic              vld_r  [ROOT_W];
  logic [DISC_W-1:0] rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  rsi_side_t         side_r [ROOT_W];

  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    localparam int B = ROOT_W - 1 - i;
    logic              vld_in;
    logic [DISC_W-1:0] rem_in;
    logic [ROOT_W-1:0] root_in;
    rsi_side_t         side_in;
    logic [DISC_W+1:0] trial;
    logic              ge;

    if (i == 0) begin : g_first
      assign vld_in  = in_vld;
      assign rem_in  = in_rad;
      assign root_in = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign side_in = side_r[i-1];
    end

    always_comb begin
      trial = ((DISC_W+2)'(root_in) << (B + 1)) | ((DISC_W+2)'(1) << (2 * B));
      ge    = {2'b00, rem_in} >= trial;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[i]  <= ge ? rem_in - trial[DISC_W-1:0] : rem_in;
      root_r[i] <= ge ? (root_in | (ROOT_W'(1) << B)) : root_in;
      side_r[i] <= side_in;
    end
  end

  assign out_vld  = vld_r[ROOT_W-1];
  assign out_root = root_r[ROOT_W-1];
  assign out_side = side_r[ROOT_W-1];

endmodule

// ===== hw/rtl/rsi_div.sv =====
// ----------------------------------------------------------------------------
// rsi_div
// pipelined restoring divider giving a q8.16 quotient and a saturation flag
// ----------------------------------------------------------------------------
module rsi_div import rsi_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  logic              in_hit,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [A_W-1:0]    in_a,
  output logic              out_vld,
  output logic              out_hit,
  output logic              out_sat,
  output logic [DIST_W-1:0] out_q
);

  logic              pre_vld_r;
  logic              pre_hit_r;
  logic              pre_sat_r;
  logic [DREM_W-1:0] pre_rem_r;
  logic [A_W-1:0]    pre_a_r;

  logic              vld_r [DIV_BITS];
  logic              hit_r [DIV_BITS];
  logic              sat_r [DIV_BITS];
  logic [DREM_W-1:0] rem_r [DIV_BITS];
  logic [A_W-1:0]    a_r   [DIV_BITS];
  logic [DIST_W-1:0] q_r   [DIV_BITS];

  // quotient reaches 256.0 when num >= a * 2^8
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_vld_r <= 1'b0;
    end else begin
      pre_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    pre_hit_r <= in_hit;
    pre_sat_r <= (A_W+SAT_SH)'(in_num) >= ((A_W+SAT_SH)'(in_a) << SAT_SH);
    pre_rem_r <= {in_num, FRAC_W'(0)};
    pre_a_r   <= in_a;
  end

  for (genvar i = 0; i < DIV_BITS; i++) begin : g_stage
    localparam int K = DIV_BITS - 1 - i;
    logic              vld_in;
    logic              hit_in;
    logic              sat_in;
    logic [DREM_W-1:0] rem_in;
    logic [A_W-1:0]    a_in;
    logic [DIST_W-1:0] q_in;
    logic [DVS_W-1:0]  dsh;
    logic              ge;

    if (i == 0) begin : g_first
      assign vld_in = pre_vld_r;
      assign hit_in = pre_hit_r;
      assign sat_in = pre_sat_r;
      assign rem_in = pre_rem_r;
      assign a_in   = pre_a_r;
      assign q_in   = '0;
    end else begin : g_next
      assign vld_in = vld_r[i-1];
      assign hit_in = hit_r[i-1];
      assign sat_in = sat_r[i-1];
      assign rem_in = rem_r[i-1];
      assign a_in   = a_r[i-1];
      assign q_in   = q_r[i-1];
    end

    always_comb begin
      dsh = DVS_W'(a_in) << K;
      ge  = DVS_W'(rem_in) >= dsh;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      hit_r[i] <= hit_in;
      sat_r[i] <= sat_in;
      rem_r[i] <= ge ? rem_in - dsh[DREM_W-1:0] : rem_in;
      a_r[i]   <= a_in;
      q_r[i]   <= ge ? (q_in | (DIST_W'(1) << K)) : q_in;
    end
  end

  assign out_vld = vld_r[DIV_BITS-1];
  assign out_hit = hit_r[DIV_BITS-1];
  assign out_sat = sat_r[DIV_BITS-1];
  assign out_q   = q_r[DIV_BITS-1];

endmodule
